[rtl/core/gdn_pkg.sv]
// ----------------------------------------------------------------------------
// Gregorian day number converter package
// Shared field widths, calendar constants, reciprocal constants for the
// constant dividers, the result record and the month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gdn_pkg;

  // Field widths of the conversion items.
  localparam int unsigned DN_W    = 25;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;

  // Register stages from an input transfer to the last pipeline stage.
  localparam int unsigned PIPE_DEPTH = 11;
  // Stages of the date to day number path before its alignment delay.
  localparam int unsigned D2N_DEPTH  = 5;

  // Command codes carried on the input side-band.
  localparam logic CMD_TO_NUM  = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Calendar constants.
  localparam logic [20:0] CJDN_BASE      = 21'd1721119;
  localparam logic [22:0] CJDN_OFFSET4   = 23'd6884477;
  localparam logic [17:0] DAYS_400Y      = 18'd146097;
  localparam logic [15:0] DAYS_100Y_X100 = 16'd36525;
  localparam logic [DN_W-1:0] CJDN_MIN   = 25'd1721426;
  localparam logic [DN_W-1:0] CJDN_MAX   = 25'd25657591;

  // Truncated reciprocals: floor(2^shift / divisor). Each estimate is either
  // exact or one short, so one compare and subtract corrects it. The divide
  // by 100 uses a reciprocal rounded up instead, which is exact over its
  // whole operand range and needs no correction.
  localparam logic [19:0] RECIP_400Y = 20'd940737;   // shift 37, divisor 146097
  localparam logic [13:0] RECIP_100Y = 14'd14698;    // shift 29, divisor 36525
  localparam logic [16:0] RECIP_C100 = 17'd83887;    // shift 23, exact below 91180

  // One conversion result.
  typedef struct packed {
    logic [DN_W-1:0]    day_number;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               ok;
  } res_t;

  // Day offset of each month within a year that starts in March.
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] mon);
    logic [8:0] offs;
    case (mon)
      4'd0:    offs = 9'd0;
      4'd1:    offs = 9'd31;
      4'd2:    offs = 9'd61;
      4'd3:    offs = 9'd92;
      4'd4:    offs = 9'd122;
      4'd5:    offs = 9'd153;
      4'd6:    offs = 9'd184;
      4'd7:    offs = 9'd214;
      4'd8:    offs = 9'd245;
      4'd9:    offs = 9'd275;
      4'd10:   offs = 9'd306;
      4'd11:   offs = 9'd337;
      default: offs = 9'd0;
    endcase
    return offs;
  endfunction

  // Length of a calendar month in a common year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gregorian_day_number_converter_unit.sv]
// ----------------------------------------------------------------------------
// Gregorian day number converter
// Converts a Gregorian date to its chronological Julian day number, with a
// date check, or a day number back to year, month and day.
//
// The request channel (s_axis) carries the command on tuser: the command
// CMD_TO_NUM takes year, month and day, CMD_TO_DATE takes a day number. The
// result channel (m_axis) returns one result per request, in order, with the
// valid flag on tuser; fields that do not belong to the command are zero.
// A request is taken in every cycle while s_axis_tready is high; it drops
// when the skid stage is full. Its result shows on m_axis_tvalid after it
// passes the eleven stages of the day number to date path (two reciprocal
// dividers with a back multiply and a correction each, then the month split)
// and the output register, which adds one more. The date to day number path
// is five stages deep and is delayed to match.
// Reset clears the valid bits of the pipeline, the output register and the
// skid stage. When the receiver stalls, the pipeline keeps running until the
// skid stage holds one extra result; s_axis_tready then drops and every
// stage holds its item until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_day_number_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // year [15:0], month [19:16], day [24:20], day_number [49:25], zero [55:50]
  input  wire logic [55:0] s_axis_tdata,
  // cmd [0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_day_number [24:0], out_year [40:25], out_month [44:41], out_day [49:45],
  // zero [55:50]
  output logic [55:0]      m_axis_tdata,
  // valid_res [0]
  output logic             m_axis_tuser
);

  logic          en;
  logic          d2n_in;
  logic          n2d_in;
  logic          d2n_v;
  logic          n2d_v;
  gdn_pkg::res_t d2n_res;
  gdn_pkg::res_t n2d_res;
  logic          pipe_v;
  gdn_pkg::res_t pipe_res;
  gdn_pkg::res_t out_res;

  assign s_axis_tready = en;

  // Steer each request to the path its command selects.
  assign d2n_in = s_axis_tvalid && (s_axis_tuser == gdn_pkg::CMD_TO_NUM);
  assign n2d_in = s_axis_tvalid && (s_axis_tuser == gdn_pkg::CMD_TO_DATE);

  gdn_d2n u_d2n (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2n_in),
    .year      (s_axis_tdata[15:0]),
    .month     (s_axis_tdata[19:16]),
    .day       (s_axis_tdata[24:20]),
    .out_valid (d2n_v),
    .res       (d2n_res)
  );

  gdn_n2d u_n2d (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (n2d_in),
    .day_number (s_axis_tdata[49:25]),
    .out_valid  (n2d_v),
    .res        (n2d_res)
  );

  // Both paths are equally deep, so at most one holds a result per slot.
  assign pipe_v   = d2n_v || n2d_v;
  assign pipe_res = n2d_v ? n2d_res : d2n_res;

  gdn_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_v),
    .in_res    (pipe_res),
    .en        (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result fields, lowest first.
  assign m_axis_tdata = {6'b0, out_res.day, out_res.month, out_res.year,
                         out_res.day_number};
  assign m_axis_tuser = out_res.ok;

  a_paths_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(d2n_v && n2d_v))
    else $error("both conversion paths deliver in the same slot");

endmodule

`default_nettype wire

[rtl/core/gdn_d2n.sv]
// ----------------------------------------------------------------------------
// Date to day number pipeline
// Checks a year/month/day date and computes its day number in five stages,
// then delays the result so that it lines up with the day number to date
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_d2n (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [gdn_pkg::YEAR_W-1:0]   year,
  input  wire logic [gdn_pkg::MONTH_W-1:0]  month,
  input  wire logic [gdn_pkg::DAY_W-1:0]    day,
  output logic                              out_valid,
  output gdn_pkg::res_t                     res
);

  localparam int unsigned DELAY = gdn_pkg::PIPE_DEPTH - gdn_pkg::D2N_DEPTH;

  // Valid bits of the five arithmetic stages.
  logic [gdn_pkg::D2N_DEPTH-1:0] v;

  // Stage 1: shift the year to start in March and check the field ranges.
  logic                          early;
  logic [gdn_pkg::YEAR_W-1:0]    sy1;
  logic [gdn_pkg::MONTH_W-1:0]   mon1;
  logic [gdn_pkg::DAY_W-1:0]     day1;
  logic [gdn_pkg::DAY_W-1:0]     len1;
  logic                          rng1;
  logic                          feb1;
  logic                          y4_1;

  // Stage 2: reciprocal product for the century split.
  logic [32:0]                   prod2;
  logic [gdn_pkg::YEAR_W-1:0]    sy2;
  logic [gdn_pkg::MONTH_W-1:0]   mon2;
  logic [gdn_pkg::DAY_W-1:0]     day2;
  logic [gdn_pkg::DAY_W-1:0]     len2;
  logic                          rng2;
  logic                          feb2;
  logic                          y4_2;

  // Stage 3: centuries, years within the century, leap check.
  logic [9:0]                    qsy;
  logic [9:0]                    cent_next;
  logic [gdn_pkg::YEAR_W-1:0]    hundreds;
  logic [6:0]                    yrs;
  logic                          leap;
  logic [gdn_pkg::DAY_W-1:0]     len_eff;
  logic [9:0]                    qc3;
  logic [6:0]                    yrs3;
  logic [gdn_pkg::MONTH_W-1:0]   mon3;
  logic [gdn_pkg::DAY_W-1:0]     day3;
  logic                          ok3;

  // Stage 4: the three partial sums.
  logic [27:0]                   part1;
  logic [15:0]                   part2;
  logic [gdn_pkg::DN_W-1:0]      part3;
  logic                          ok4;

  // Stage 5: final sum.
  gdn_pkg::res_t                 res5;
  logic [gdn_pkg::DN_W-1:0]      dn;

  // Alignment delay.
  logic [DELAY-1:0]              dv;
  gdn_pkg::res_t                 dres [DELAY];

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      dv <= '0;
    end else if (en) begin
      v  <= {v[gdn_pkg::D2N_DEPTH-2:0], in_valid};
      dv <= {dv[DELAY-2:0], v[gdn_pkg::D2N_DEPTH-1]};
    end
  end

  // Stage 1.
  assign early = (month < gdn_pkg::MONTH_MAR);

  always_ff @(posedge clk) begin
    if (en) begin
      sy1  <= early ? year - 16'd1 : year;
      mon1 <= early ? month + 4'd9 : month - gdn_pkg::MONTH_MAR;
      day1 <= day;
      len1 <= gdn_pkg::month_len(month);
      rng1 <= (year != '0) && (month >= gdn_pkg::MONTH_JAN) &&
              (month <= gdn_pkg::MONTH_DEC) && (day != '0);
      feb1 <= (month == gdn_pkg::MONTH_FEB);
      y4_1 <= (year[1:0] == 2'b00);
    end
  end

  // Stage 2.
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= 33'(sy1) * 33'(gdn_pkg::RECIP_C100);
      sy2   <= sy1;
      mon2  <= mon1;
      day2  <= day1;
      len2  <= len1;
      rng2  <= rng1;
      feb2  <= feb1;
      y4_2  <= y4_1;
    end
  end

  // Stage 3. For February the shifted year is one less than the year, so a
  // century year shows up as 99 years into the previous century. A century
  // year is leap when its century count is a multiple of four but not of 32.
  always_comb begin
    qsy       = prod2[32:23];
    hundreds  = 16'(qsy) * 16'd100;
    yrs       = 7'(sy2 - hundreds);
    cent_next = qsy + 10'd1;
    leap      = y4_2 && ((yrs != 7'd99) ||
                         ((cent_next[1:0] == 2'b00) && (cent_next[4:0] != 5'd0)));
    len_eff   = (feb2 && leap) ? 5'd29 : len2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qc3  <= qsy;
      yrs3 <= yrs;
      mon3 <= mon2;
      day3 <= day2;
      ok3  <= rng2 && (day2 <= len_eff);
    end
  end

  // Stage 4. The years term 36525 * y / 100 equals 365 * y + y / 4.
  always_ff @(posedge clk) begin
    if (en) begin
      part1 <= 28'(qc3) * 28'(gdn_pkg::DAYS_400Y);
      part2 <= 16'(yrs3) * 16'd365 + 16'(yrs3 >> 2);
      part3 <= 25'(gdn_pkg::CJDN_BASE) + 25'(gdn_pkg::month_start(mon3)) + 25'(day3);
      ok4   <= ok3;
    end
  end

  // Stage 5.
  assign dn = 25'(part1 >> 2) + 25'(part2) + part3;

  always_ff @(posedge clk) begin
    if (en) begin
      res5.day_number <= ok4 ? dn : '0;
      res5.year       <= '0;
      res5.month      <= '0;
      res5.day        <= '0;
      res5.ok         <= ok4;
    end
  end

  // Alignment delay to the depth of the other path.
  always_ff @(posedge clk) begin
    if (en) begin
      dres[0] <= res5;
      for (int i = 1; i < DELAY; i++) begin
        dres[i] <= dres[i-1];
      end
    end
  end

  assign out_valid = dv[DELAY-1];
  assign res       = dres[DELAY-1];

  // A date that passed the check always lands inside the supported span.
  a_dn_span: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.ok) |->
      (res.day_number >= gdn_pkg::CJDN_MIN && res.day_number <= gdn_pkg::CJDN_MAX))
    else $error("day number of a valid date out of span");

  a_dn_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.year == '0 && res.month == '0 && res.day == '0))
    else $error("date fields set by the day number path");

endmodule

`default_nettype wire

[rtl/core/gdn_n2d.sv]
// ----------------------------------------------------------------------------
// Day number to date pipeline
// Splits a day number into centuries, years, months and days through
// reciprocal-multiply dividers with a correction step, in eleven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_n2d (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [gdn_pkg::DN_W-1:0]   day_number,
  output logic                            out_valid,
  output gdn_pkg::res_t                   res
);

  localparam int unsigned N = gdn_pkg::PIPE_DEPTH;

  // Valid and range flags travel together through every stage.
  logic [N-1:0] v;
  logic [N-1:0] ok;
  logic         in_ok;

  // Stage registers.
  logic [26:0] t1, t2, t3;
  logic [46:0] pc2;
  logic [9:0]  q3, qc4, qc5, qc6, qc7, qc8;
  logic [27:0] prod3;
  logic [27:0] diff4;
  logic        ge4;
  logic [17:0] rc4;
  logic [21:0] t5, t6, t7;
  logic [35:0] py6;
  logic [6:0]  qy7, qy8;
  logic [21:0] prody7;
  logic [21:0] diff8;
  logic        ge8;
  logic [15:0] ry8;
  logic [32:0] pidx9;
  logic [16:0] yb9, yb10;
  logic [8:0]  idx;
  logic [8:0]  idx10;
  logic [3:0]  mon;
  logic [3:0]  mon10;
  logic        carry;
  gdn_pkg::res_t res11;

  assign in_ok = (day_number >= gdn_pkg::CJDN_MIN) && (day_number <= gdn_pkg::CJDN_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok <= {ok[N-2:0], in_ok};
    end
  end

  // Stage 1: scale and offset the day number.
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= {day_number, 2'b00} - 27'(gdn_pkg::CJDN_OFFSET4);
    end
  end

  // Stage 2: reciprocal product for the 400-year split.
  always_ff @(posedge clk) begin
    if (en) begin
      pc2 <= 47'(t1) * 47'(gdn_pkg::RECIP_400Y);
      t2  <= t1;
    end
  end

  // Stage 3: back-multiply the century estimate.
  always_ff @(posedge clk) begin
    if (en) begin
      q3    <= pc2[46:37];
      prod3 <= 28'(pc2[46:37]) * 28'(gdn_pkg::DAYS_400Y);
      t3    <= t2;
    end
  end

  // Stage 4: remainder with one correction step.
  always_comb begin
    diff4 = 28'(t3) - prod3;
    ge4   = (diff4 >= 28'(gdn_pkg::DAYS_400Y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc4 <= ge4 ? 18'(diff4 - 28'(gdn_pkg::DAYS_400Y)) : 18'(diff4);
      qc4 <= q3 + 10'(ge4);
    end
  end

  // Stage 5: dividend for the year split.
  always_ff @(posedge clk) begin
    if (en) begin
      t5  <= 22'(rc4[17:2]) * 22'd100 + 22'd99;
      qc5 <= qc4;
    end
  end

  // Stage 6: reciprocal product for the year split.
  always_ff @(posedge clk) begin
    if (en) begin
      py6 <= 36'(t5) * 36'(gdn_pkg::RECIP_100Y);
      t6  <= t5;
      qc6 <= qc5;
    end
  end

  // Stage 7: back-multiply the year estimate.
  always_ff @(posedge clk) begin
    if (en) begin
      qy7    <= py6[35:29];
      prody7 <= 22'(py6[35:29]) * 22'(gdn_pkg::DAYS_100Y_X100);
      t7     <= t6;
      qc7    <= qc6;
    end
  end

  // Stage 8: year remainder with one correction step.
  always_comb begin
    diff8 = t7 - prody7;
    ge8   = (diff8 >= 22'(gdn_pkg::DAYS_100Y_X100));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ry8 <= ge8 ? 16'(diff8 - 22'(gdn_pkg::DAYS_100Y_X100)) : 16'(diff8);
      qy8 <= qy7 + 7'(ge8);
      qc8 <= qc7;
    end
  end

  // Stage 9: day of the March-based year and the year before month carry.
  always_ff @(posedge clk) begin
    if (en) begin
      pidx9 <= 33'(ry8) * 33'(gdn_pkg::RECIP_C100);
      yb9   <= 17'(qc8) * 17'd100 + 17'(qy8);
    end
  end

  // Stage 10: find the month by comparing against every month start.
  always_comb begin
    idx = pidx9[31:23];
    mon = '0;
    for (int m = 1; m < 12; m++) begin
      if (idx >= gdn_pkg::month_start(4'(m))) begin
        mon = 4'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx10 <= idx;
      mon10 <= mon;
      yb10  <= yb9;
    end
  end

  // Stage 11: day of month, and carry of January and February into the
  // following year.
  assign carry = (mon10 >= 4'd10);

  always_ff @(posedge clk) begin
    if (en) begin
      res11.day_number <= '0;
      res11.ok         <= ok[N-2];
      if (ok[N-2]) begin
        res11.year  <= 16'(yb10 + 17'(carry));
        res11.month <= carry ? mon10 - 4'd9 : mon10 + gdn_pkg::MONTH_MAR;
        res11.day   <= 5'(idx10 - gdn_pkg::month_start(mon10) + 9'd1);
      end else begin
        res11.year  <= '0;
        res11.month <= '0;
        res11.day   <= '0;
      end
    end
  end

  assign out_valid = v[N-1];
  assign res       = res11;

  // An accepted day number always gives a real calendar date.
  a_date_legal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.ok) |->
      (res.year != '0 && res.month >= gdn_pkg::MONTH_JAN &&
       res.month <= gdn_pkg::MONTH_DEC && res.day != '0))
    else $error("day number converted to an impossible date");

endmodule

`default_nettype wire

[rtl/core/gdn_skid.sv]
// ----------------------------------------------------------------------------
// Output register with skid stage
// Holds the result presented on the output channel and catches one more
// result while the receiver stalls, so the pipeline enable is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_skid (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  gdn_pkg::res_t  in_res,
  output logic           en,
  output logic           out_valid,
  input  wire logic      out_ready,
  output gdn_pkg::res_t  out_res
);

  logic          skid_valid;
  gdn_pkg::res_t skid_res;
  logic          take;
  logic          slot_free;

  assign en        = !skid_valid;
  assign take      = en && in_valid;
  assign slot_free = out_ready || !out_valid;

  // Control: the skid stage fills only when the output slot is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_res <= skid_valid ? skid_res : in_res;
    end
    if (!slot_free && take) begin
      skid_res <= in_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output slot empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid stage filled without a stalled output");

endmodule

`default_nettype wire

[tb/gregorian_day_number_converter_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day number converter checker
// Watches the request and result channels of the converter. Every request
// transfer is converted here into the result it should give, and every
// result transfer is compared field by field with the oldest such result.
// ----------------------------------------------------------------------------

module gregorian_day_number_converter_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // year [15:0], month [19:16], day [24:20], day_number [49:25], zero [55:50]
  input  wire logic [55:0] s_axis_tdata,
  // cmd [0]
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_day_number [24:0], out_year [40:25], out_month [44:41], out_day [49:45],
  // zero [55:50]
  input  wire logic [55:0] m_axis_tdata,
  // valid_res [0]
  input  wire logic        m_axis_tuser,
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               valid_seen
);

  localparam longint unsigned MONTH_SPAN    = 153;
  localparam longint unsigned NO_LEAP_CYCLE = 3200;
  localparam int              REPORT_LIMIT  = 10;

  // Conversion results still owed by the converter, oldest first.
  gdn_pkg::res_t conversions_due[$];
  gdn_pkg::res_t got;
  gdn_pkg::res_t want;
  int   mismatch_count = 0;
  int   result_count   = 0;
  int   valid_count    = 0;

  // Works out the result of one request. The date check carries the 3200-year
  // rule; the conversion formulas themselves are plain proleptic Gregorian.
  function automatic gdn_pkg::res_t convert_request(input logic cmd,
                                                    input longint unsigned y,
                                                    input longint unsigned m,
                                                    input longint unsigned d,
                                                    input longint unsigned n);
    gdn_pkg::res_t   r;
    longint unsigned last_day;
    longint unsigned sy;
    longint unsigned mon;
    longint unsigned t;
    longint unsigned cent;
    longint unsigned yrs;
    longint unsigned carry;
    bit              leap;
    bit              date_ok;
    r = '0;
    if (cmd == gdn_pkg::CMD_TO_NUM) begin
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)) && (y % NO_LEAP_CYCLE != 0);
      if (m == gdn_pkg::MONTH_FEB) begin
        last_day = leap ? 29 : 28;
      end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
        last_day = 30;
      end else begin
        last_day = 31;
      end
      date_ok = (y >= 1) && (m >= gdn_pkg::MONTH_JAN) && (m <= gdn_pkg::MONTH_DEC) &&
                (d >= 1) && (d <= last_day);
      if (date_ok) begin
        // The year is taken to start in March so that a leap day falls last.
        if (m < gdn_pkg::MONTH_MAR) begin
          sy  = y - 1;
          mon = m + 9;
        end else begin
          sy  = y;
          mon = m - 3;
        end
        t = (gdn_pkg::DAYS_400Y * (sy / 100)) / 4 +
            (gdn_pkg::DAYS_100Y_X100 * (sy % 100)) / 100 +
            (MONTH_SPAN * mon + 2) / 5 + d + gdn_pkg::CJDN_BASE;
        r.day_number = t[gdn_pkg::DN_W-1:0];
        r.ok         = 1'b1;
      end
    end else if (n >= gdn_pkg::CJDN_MIN && n <= gdn_pkg::CJDN_MAX) begin
      // Peel off 400-year cycles, then years, then months of the March year.
      t     = 4 * n - gdn_pkg::CJDN_OFFSET4;
      cent  = t / gdn_pkg::DAYS_400Y;
      t     = ((t % gdn_pkg::DAYS_400Y) / 4) * 100 + 99;
      yrs   = t / gdn_pkg::DAYS_100Y_X100;
      t     = ((t % gdn_pkg::DAYS_100Y_X100) / 100) * 5 + 2;
      mon   = t / MONTH_SPAN;
      d     = (t % MONTH_SPAN) / 5 + 1;
      carry = (mon + 2) / 12;
      y     = 100 * cent + yrs + carry;
      m     = mon + 3 - 12 * carry;
      r.year  = y[gdn_pkg::YEAR_W-1:0];
      r.month = m[gdn_pkg::MONTH_W-1:0];
      r.day   = d[gdn_pkg::DAY_W-1:0];
      r.ok    = 1'b1;
    end
    return r;
  endfunction

  // Both channels are sampled at the rising edge, before any driver updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        conversions_due.push_back(convert_request(s_axis_tuser,
                                                  64'(s_axis_tdata[15:0]),
                                                  64'(s_axis_tdata[19:16]),
                                                  64'(s_axis_tdata[24:20]),
                                                  64'(s_axis_tdata[49:25])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.day_number = m_axis_tdata[24:0];
        got.year       = m_axis_tdata[40:25];
        got.month      = m_axis_tdata[44:41];
        got.day        = m_axis_tdata[49:45];
        got.ok         = m_axis_tuser;
        result_count++;
        if (got.ok === 1'b1) valid_count++;
        if (conversions_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result transfer with nothing owed: dn=%0d y=%0d m=%0d d=%0d ok=%b",
                     $time, got.day_number, got.year, got.month, got.day, got.ok);
          end
        end else begin
          want = conversions_due.pop_front();
          if (got.day_number !== want.day_number || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day || got.ok !== want.ok ||
              m_axis_tdata[55:50] !== 6'd0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: expected dn=%0d y=%0d m=%0d d=%0d ok=%b", $time,
                       want.day_number, want.year, want.month, want.day, want.ok);
              $display("%0t:   actual dn=%0d y=%0d m=%0d d=%0d ok=%b pad=%h", $time,
                       got.day_number, got.year, got.month, got.day, got.ok,
                       m_axis_tdata[55:50]);
            end
          end
        end
      end
    end
    mismatches   <= mismatch_count;
    pending      <= conversions_due.size();
    results_seen <= result_count;
    valid_seen   <= valid_count;
  end

endmodule

[tb/gregorian_day_number_converter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day number converter testbench
// Drives date and day number requests into the converter: a directed set of
// calendar corner cases, then random requests, mostly well formed, with
// random gaps on both channels and long receiver hold-offs. A separate
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module gregorian_day_number_converter_unit_test;

  localparam int unsigned YEAR_W  = gdn_pkg::YEAR_W;
  localparam int unsigned MONTH_W = gdn_pkg::MONTH_W;
  localparam int unsigned DAY_W   = gdn_pkg::DAY_W;
  localparam int unsigned DN_W    = gdn_pkg::DN_W;

  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // Day numbers around the 3200 leap day, which only the date check rejects.
  localparam logic [DN_W-1:0] DN_3200_FEB_28 = 25'd2889894;
  localparam logic [DN_W-1:0] DN_3200_FEB_29 = 25'd2889895;
  localparam logic [DN_W-1:0] DN_3200_MAR_01 = 25'd2889896;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatches;
  int pending;
  int results_seen;
  int valid_seen;
  int date_requests   = 0;
  int number_requests = 0;
  int hold_offs       = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;

  always #10 clk = ~clk;

  gregorian_day_number_converter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gregorian_day_number_converter_unit_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .pending       (pending),
    .results_seen  (results_seen),
    .valid_seen    (valid_seen)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Years biased towards the ends of the range and the leap rule boundaries.
  function automatic logic [YEAR_W-1:0] random_year();
    case ($urandom_range(0, 9))
      0:       return YEAR_W'($urandom_range(1, 12));
      1:       return YEAR_W'($urandom_range(65524, 65535));
      2:       return YEAR_W'($urandom_range(1, 20) * 3200);
      3:       return YEAR_W'($urandom_range(1, 163) * 400);
      4:       return YEAR_W'($urandom_range(1, 655) * 100);
      5:       return YEAR_W'($urandom_range(1, 16383) * 4);
      default: return YEAR_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // Offers one request and holds it until the transfer, then idles a while
  // unless a burst is running.
  task automatic send_request(input logic cmd, input logic [YEAR_W-1:0] y,
                              input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                              input logic [DN_W-1:0] n);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, n, d, m, y};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == gdn_pkg::CMD_TO_NUM) date_requests++;
    else number_requests++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = random_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // A date request; the day number field carries random noise.
  task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                           input logic [DAY_W-1:0] d);
    send_request(gdn_pkg::CMD_TO_NUM, y, m, d, DN_W'($urandom));
  endtask

  // A day number request; the date fields carry random noise.
  task automatic send_number(input logic [DN_W-1:0] n);
    send_request(gdn_pkg::CMD_TO_DATE, YEAR_W'($urandom), MONTH_W'($urandom),
                 DAY_W'($urandom), n);
  endtask

  // Mostly well-formed dates and in-span day numbers, some near the span
  // limits, and the rest noise over every bit.
  task automatic send_random_request();
    int unsigned      pick;
    logic [DAY_W-1:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      d = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom_range(28, 31)) :
                                        DAY_W'($urandom_range(1, 28));
      send_date(random_year(), MONTH_W'($urandom_range(1, 12)), d);
    end else if (pick < 48) begin
      send_date(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
    end else if (pick < 85) begin
      send_number(DN_W'($urandom_range(gdn_pkg::CJDN_MIN, gdn_pkg::CJDN_MAX)));
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) == 0) begin
        send_number(DN_W'(gdn_pkg::CJDN_MIN - 4 + $urandom_range(0, 8)));
      end else begin
        send_number(DN_W'(gdn_pkg::CJDN_MAX - 4 + $urandom_range(0, 8)));
      end
    end else begin
      send_number(DN_W'($urandom));
    end
  endtask

  // Request side: reset, directed corner cases, random traffic, then drain.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Range ends, year zero, bad months and days, and the leap rules.
    send_date(16'd1, gdn_pkg::MONTH_JAN, 5'd1);
    send_date(16'd65535, gdn_pkg::MONTH_DEC, 5'd31);
    send_date(16'd0, gdn_pkg::MONTH_JAN, 5'd1);
    send_date(16'd2024, 4'd0, 5'd10);
    send_date(16'd2024, 4'd13, 5'd1);
    send_date(16'd65535, 4'd15, 5'd31);
    send_date(16'd2024, 4'd6, 5'd0);
    send_date(16'd2023, 4'd4, 5'd31);
    send_date(16'd2000, gdn_pkg::MONTH_FEB, 5'd29);
    send_date(16'd1900, gdn_pkg::MONTH_FEB, 5'd29);
    send_date(16'd2023, gdn_pkg::MONTH_FEB, 5'd29);
    send_date(16'd3200, gdn_pkg::MONTH_FEB, 5'd29);
    send_date(16'd6400, gdn_pkg::MONTH_FEB, 5'd29);
    send_date(16'd3200, gdn_pkg::MONTH_FEB, 5'd28);
    send_date(16'd2024, gdn_pkg::MONTH_MAR, 5'd1);
    send_date(16'd2024, gdn_pkg::MONTH_JAN, 5'd31);

    // Day numbers at and beyond the span, and across the 3200 leap day.
    send_number('0);
    send_number(gdn_pkg::CJDN_MIN - 25'd1);
    send_number(gdn_pkg::CJDN_MIN);
    send_number(gdn_pkg::CJDN_MAX);
    send_number(gdn_pkg::CJDN_MAX + 25'd1);
    send_number('1);
    send_number(DN_3200_FEB_28);
    send_number(DN_3200_FEB_29);
    send_number(DN_3200_MAR_01);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
      send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last transfer before waiting for the results.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * gdn_pkg::PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d date and %0d day number requests; %0d results came back, %0d valid.",
             date_requests, number_requests, results_seen, valid_seen);
    $display("The receiver held off %0d times for %0d cycles, with random gaps on both sides.",
             hold_offs, HOLD_OFF_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("gregorian_day_number_converter_unit_test passed");
    end else begin
      $display("gregorian_day_number_converter_unit_test failed");
    end
    $finish;
  end

  // Result side: random ready and stall stretches, with two long hold-offs
  // that let the converter fill up and stall its input.
  initial begin
    int unsigned rounds;
    int unsigned stall;
    rounds = 0;
    do @(posedge clk); while (rst);
    forever begin
      rounds++;
      if (rounds == 20 || rounds == 200) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs++;
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8))
        @(posedge clk);
      stall = random_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("gregorian_day_number_converter_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
